@@ rtl/sbca_pkg.sv @@
// Shared types and constants of the SRAM bank crossbar arbiter.
package sbca_pkg;

  localparam int NUM_BANKS  = 3;
  localparam int BANK_SHIFT = 13;        // banks are placed in 8 KiB steps
  localparam int ADDR_W     = 32;
  localparam int BANK_W     = 2;
  localparam int IN_W       = 104;
  localparam int OUT_W      = 16;
  localparam int CFG_AW     = 5;

  // Configuration register indexes (byte address bits [4:2])
  localparam logic [2:0] REG_WINDOW_BASE  = 3'd0;
  localparam logic [2:0] REG_WINDOW_END   = 3'd1;
  localparam logic [2:0] REG_BANK0_OFFSET = 3'd2;
  localparam logic [2:0] REG_BANK1_OFFSET = 3'd3;
  localparam logic [2:0] REG_BANK2_OFFSET = 3'd4;

  typedef enum logic {
    SBCA_IDLE,
    SBCA_ACTIVE
  } sbca_state_t;

  // Inclusive span of each bank plus the window limits
  typedef struct packed {
    logic [ADDR_W-1:0]                win_base;
    logic [ADDR_W-1:0]                win_end;
    logic [NUM_BANKS-1:0][ADDR_W-1:0] first;
    logic [NUM_BANKS-1:0][ADDR_W-1:0] last;
  } sbca_bounds_t;

  // Decode outcome for one address
  typedef struct packed {
    logic              hit;
    logic [BANK_W-1:0] bank;
    logic              outside;
  } sbca_dec_t;

  // Input item, last field in the lowest bits
  typedef struct packed {
    logic              pad;
    logic              done1;
    logic              done0;
    logic              start1;
    logic              start0;
    logic [ADDR_W-1:0] bus_address;
    logic              bus_valid;
    logic [ADDR_W-1:0] master1_address;
    logic              master1_valid;
    logic [ADDR_W-1:0] master0_address;
    logic              master0_valid;
  } sbca_item_t;

  // Result item, last field in the lowest bits
  typedef struct packed {
    logic                 pad;
    logic                 bus_held;
    logic [BANK_W-1:0]    bus_bank;
    logic                 bus_ack;
    logic [1:0]           master_ack_mask;
    logic [NUM_BANKS-1:0] bank_request_mask;
    logic                 address_error;
    logic                 bank_collision;
    logic [1:0]           dropped_mask;
    logic [1:0]           accepted_mask;
  } sbca_result_t;

endpackage

@@ rtl/sbca_decode.sv @@
// Address to bank decode with window check.
module sbca_decode (
  input  logic [sbca_pkg::ADDR_W-1:0] addr,
  input  sbca_pkg::sbca_bounds_t      bounds,
  output sbca_pkg::sbca_dec_t         dec
);

  logic [sbca_pkg::NUM_BANKS-1:0] in_span;

  // Inverted or empty spans fall out of the two compares naturally
  always_comb begin
    for (int b = 0; b < sbca_pkg::NUM_BANKS; b++) begin
      in_span[b] = (addr >= bounds.first[b]) && (addr <= bounds.last[b]);
    end
  end

  always_comb begin
    dec.outside = (addr < bounds.win_base) || (addr > bounds.win_end);
    dec.hit     = |in_span;
    priority if (in_span[0]) begin
      dec.bank = sbca_pkg::BANK_W'(0);
    end else if (in_span[1]) begin
      dec.bank = sbca_pkg::BANK_W'(1);
    end else if (in_span[2]) begin
      dec.bank = sbca_pkg::BANK_W'(2);
    end else begin
      dec.bank = sbca_pkg::BANK_W'(0);
    end
  end

endmodule

@@ rtl/sram_bank_crossbar_arbiter.sv @@
// Top level of the SRAM bank crossbar arbiter: decode, arbitration, bus slot, state.
// The input register takes the transfer, one decode and arbitration pass fills
// the result register. Throughput: one item per cycle unless out_tready stalls; the
// single pass through three bank decoders and the arbitration logic sets this.
// in_tready follows out_tready once both registers hold.
// Reset (rst_n low, synchronous): Idle, no running masters, pending slot empty,
// both channel registers empty, all configuration registers zero.
module sram_bank_crossbar_arbiter (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // master0_valid, master0_address, master1_valid, master1_address, bus_valid,
  // bus_address, start0, start1, done0, done1, zero pad (lowest bit first)
  input  logic [sbca_pkg::IN_W-1:0]    in_tdata,
  // result channel
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // accepted_mask, dropped_mask, bank_collision, address_error, bank_request_mask,
  // master_ack_mask, bus_ack, bus_bank, bus_held, zero pad (lowest bit first)
  output logic [sbca_pkg::OUT_W-1:0]   out_tdata,
  // configuration port
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [sbca_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);

  // Configuration registers
  logic [31:0]                    win_base_r;
  logic [31:0]                    win_end_r;
  logic [2:0][7:0]                bank_off_r;
  logic [2:0]                     cfg_idx;
  logic                           cfg_wr;

  // Channel registers
  sbca_pkg::sbca_item_t           item_r;
  logic                           item_vld_r;
  sbca_pkg::sbca_result_t         result_r;
  sbca_pkg::sbca_result_t         result_nxt;
  logic                           out_vld_r;
  logic                           in_fire;
  logic                           adv;

  // Arbitration state
  sbca_pkg::sbca_state_t          state_r, state_nxt;
  logic [1:0]                     running_r, running_nxt;
  logic                           over_r, over_nxt;
  logic                           pend_r, pend_nxt;
  logic [31:0]                    pend_addr_r, pend_addr_nxt;

  sbca_pkg::sbca_bounds_t         bounds;
  sbca_pkg::sbca_dec_t            dec_m0, dec_m1, dec_bus;
  logic [31:0]                    bus_eff_addr;

  // ---------------------------------------------------------------------------
  // Configuration port: write on the access phase, read back unregistered
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_base_r <= '0;
      win_end_r  <= '0;
      bank_off_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        sbca_pkg::REG_WINDOW_BASE:  win_base_r    <= cfg_pwdata;
        sbca_pkg::REG_WINDOW_END:   win_end_r     <= cfg_pwdata;
        sbca_pkg::REG_BANK0_OFFSET: bank_off_r[0] <= cfg_pwdata[7:0];
        sbca_pkg::REG_BANK1_OFFSET: bank_off_r[1] <= cfg_pwdata[7:0];
        sbca_pkg::REG_BANK2_OFFSET: bank_off_r[2] <= cfg_pwdata[7:0];
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      sbca_pkg::REG_WINDOW_BASE:  cfg_prdata = win_base_r;
      sbca_pkg::REG_WINDOW_END:   cfg_prdata = win_end_r;
      sbca_pkg::REG_BANK0_OFFSET: cfg_prdata = {24'd0, bank_off_r[0]};
      sbca_pkg::REG_BANK1_OFFSET: cfg_prdata = {24'd0, bank_off_r[1]};
      sbca_pkg::REG_BANK2_OFFSET: cfg_prdata = {24'd0, bank_off_r[2]};
      default:                    cfg_prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Bank bounds: start = base + offset * 8 KiB, wrapping at 32 bits.
  // Each bank ends one below the next start; the last ends one below window_end.
  // ---------------------------------------------------------------------------
  always_comb begin
    bounds.win_base = win_base_r;
    bounds.win_end  = win_end_r;
    for (int b = 0; b < sbca_pkg::NUM_BANKS; b++) begin
      bounds.first[b] = win_base_r + (32'(bank_off_r[b]) << sbca_pkg::BANK_SHIFT);
    end
    bounds.last[0] = bounds.first[1] - 32'd1;
    bounds.last[1] = bounds.first[2] - 32'd1;
    bounds.last[2] = win_end_r - 32'd1;
  end

  // ---------------------------------------------------------------------------
  // Channel handshake: advance the held item whenever the result register is
  // free or being drained in the same cycle.
  // ---------------------------------------------------------------------------
  assign adv       = item_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !item_vld_r || adv;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (in_fire) begin
        item_vld_r <= 1'b1;
      end else if (adv) begin
        item_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= sbca_pkg::sbca_item_t'(in_tdata);
    end
    if (adv) begin
      result_r <= result_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = result_r;

  // ---------------------------------------------------------------------------
  // Decoders: one per master, one for the effective bus request
  // ---------------------------------------------------------------------------
  assign bus_eff_addr = item_r.bus_valid ? item_r.bus_address : pend_addr_r;

  sbca_decode u_dec_m0 (
    .addr   (item_r.master0_address),
    .bounds (bounds),
    .dec    (dec_m0)
  );

  sbca_decode u_dec_m1 (
    .addr   (item_r.master1_address),
    .bounds (bounds),
    .dec    (dec_m1)
  );

  sbca_decode u_dec_bus (
    .addr   (bus_eff_addr),
    .bounds (bounds),
    .dec    (dec_bus)
  );

  // ---------------------------------------------------------------------------
  // Arbitration and bus slot. Master 1 is examined after master 0, so it takes
  // a shared bank and master 0 is marked as dropped.
  // ---------------------------------------------------------------------------
  logic                           act;
  logic                           hit0, hit1, coll;
  logic [sbca_pkg::NUM_BANKS-1:0] won;
  logic                           bus_eff;
  logic                           bus_ack;
  logic [sbca_pkg::BANK_W-1:0]    bus_bank;
  logic [sbca_pkg::NUM_BANKS-1:0] bus_sel;
  logic                           err;

  always_comb begin
    act      = (state_r == sbca_pkg::SBCA_ACTIVE);
    hit0     = act && item_r.master0_valid && dec_m0.hit;
    hit1     = act && item_r.master1_valid && dec_m1.hit;
    coll     = hit0 && hit1 && (dec_m0.bank == dec_m1.bank);
    won      = ({sbca_pkg::NUM_BANKS{hit0}} & (3'd1 << dec_m0.bank))
             | ({sbca_pkg::NUM_BANKS{hit1}} & (3'd1 << dec_m1.bank));

    bus_eff  = item_r.bus_valid || pend_r;
    // holes and other bus addresses outside every bank span fall back to bank 0
    bus_bank = dec_bus.hit ? dec_bus.bank : sbca_pkg::BANK_W'(0);
    bus_sel  = 3'd1 << bus_bank;
    bus_ack  = bus_eff && (!act || ((won & bus_sel) == '0));

    err = (act && item_r.master0_valid && !dec_m0.hit && dec_m0.outside)
       || (act && item_r.master1_valid && !dec_m1.hit && dec_m1.outside)
       || (bus_eff && !dec_bus.hit && dec_bus.outside);

    // pending slot: store an unserved new request, clear once a lone pending
    // request is served
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    if (item_r.bus_valid && !bus_ack) begin
      pend_nxt      = 1'b1;
      pend_addr_nxt = item_r.bus_address;
    end else if (!item_r.bus_valid && pend_r && bus_ack) begin
      pend_nxt      = 1'b0;
      pend_addr_nxt = '0;
    end

    result_nxt                   = '0;
    result_nxt.accepted_mask     = {hit1, hit0 && !coll};
    result_nxt.dropped_mask      = {1'b0, coll};
    result_nxt.bank_collision    = coll;
    result_nxt.address_error     = err;
    result_nxt.bank_request_mask = won | ({sbca_pkg::NUM_BANKS{bus_ack}} & bus_sel);
    result_nxt.master_ack_mask   = {hit1, hit0};
    result_nxt.bus_ack           = bus_ack;
    result_nxt.bus_bank          = bus_eff ? bus_bank : sbca_pkg::BANK_W'(0);
    result_nxt.bus_held          = pend_nxt;
  end

  // ---------------------------------------------------------------------------
  // Idle/Active state machine. Start wins over done while Active; leave Active
  // once the masters have all finished (now or earlier) and no bus request was
  // waiting at the start of the cycle.
  // ---------------------------------------------------------------------------
  logic over_now;
  logic leave;

  always_comb begin
    over_now    = act && (running_r == 2'b00);
    leave       = act && (over_now || over_r) && !pend_r;
    state_nxt   = state_r;
    running_nxt = running_r;
    over_nxt    = over_r;
    unique case (state_r)
      sbca_pkg::SBCA_IDLE: begin
        running_nxt = {item_r.start1, item_r.start0};
        over_nxt    = 1'b0;
        state_nxt   = (item_r.start0 || item_r.start1) ? sbca_pkg::SBCA_ACTIVE
                                                       : sbca_pkg::SBCA_IDLE;
      end
      sbca_pkg::SBCA_ACTIVE: begin
        running_nxt[0] = item_r.start0 || (running_r[0] && !item_r.done0);
        running_nxt[1] = item_r.start1 || (running_r[1] && !item_r.done1);
        over_nxt       = over_r || over_now;
        state_nxt      = leave ? sbca_pkg::SBCA_IDLE : sbca_pkg::SBCA_ACTIVE;
      end
      default: begin
        state_nxt = sbca_pkg::SBCA_IDLE;
      end
    endcase
  end

  // Hold all state until the item advances into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sbca_pkg::SBCA_IDLE;
      running_r   <= 2'b00;
      over_r      <= 1'b0;
      pend_r      <= 1'b0;
      pend_addr_r <= '0;
    end else if (adv) begin
      state_r     <= state_nxt;
      running_r   <= running_nxt;
      over_r      <= over_nxt;
      pend_r      <= pend_nxt;
      pend_addr_r <= pend_addr_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_idle_no_master: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (state_r == sbca_pkg::SBCA_IDLE)
      |=> (result_r.accepted_mask == 2'b00) && (result_r.master_ack_mask == 2'b00))
    else $error("master granted while idle");

  a_slot_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !pend_r |-> (pend_addr_r == '0))
    else $error("empty pending slot holds an address");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a stalled result");

  a_stay_active: assert property (@(posedge clk) disable iff (!rst_n)
    adv && act && pend_r |=> (state_r == sbca_pkg::SBCA_ACTIVE))
    else $error("left active with a bus request pending");

  a_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((result_r.accepted_mask & result_r.dropped_mask) == 2'b00))
    else $error("master both accepted and dropped");

endmodule
